// File: src/chbc_pkg.sv
// Shared types and constants for the click and hold brightness controller.
package chbc_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int TIMER_W     = 16;
  localparam int LOCKOUT_W   = 10;
  localparam int DUTY_W      = 8;
  localparam int LEVEL_W     = 2;
  localparam int FLASH_W     = 9;
  localparam int DUTY_CNT    = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_HOLD_TIME    = 3'd0,
    CFG_REPEAT_INTVL = 3'd1,
    CFG_HB_PERIOD    = 3'd2,
    CFG_LOCKOUT      = 3'd3,
    CFG_DUTY_0       = 3'd4,
    CFG_DUTY_1       = 3'd5,
    CFG_DUTY_2       = 3'd6,
    CFG_DUTY_3       = 3'd7
  } cfg_reg_t;

  // Flash positions run 1..FLASH_END; lit up to ON1_END and after OFF_END.
  localparam logic [FLASH_W-1:0] FLASH_ON1_END = 9'd150;
  localparam logic [FLASH_W-1:0] FLASH_OFF_END = 9'd250;
  localparam logic [FLASH_W-1:0] FLASH_END     = 9'd400;

  localparam logic [TIMER_W-1:0]   RST_HOLD_TIME    = 16'd500;
  localparam logic [TIMER_W-1:0]   RST_REPEAT_INTVL = 16'd500;
  localparam logic [TIMER_W-1:0]   RST_HB_PERIOD    = 16'd10000;
  localparam logic [LOCKOUT_W-1:0] RST_LOCKOUT      = 10'd300;
  localparam logic [DUTY_W-1:0]    RST_DUTY_0       = 8'd64;
  localparam logic [DUTY_W-1:0]    RST_DUTY_1       = 8'd127;
  localparam logic [DUTY_W-1:0]    RST_DUTY_2       = 8'd191;
  localparam logic [DUTY_W-1:0]    RST_DUTY_3       = 8'd255;

  function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
    return (v == {TIMER_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

// File: src/chbc_heartbeat.sv
// Heartbeat period counter and double-flash sequencer.
module chbc_heartbeat (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    advance,
  input  logic [chbc_pkg::TIMER_W-1:0] period,
  output logic                    led_nxt
);
  import chbc_pkg::*;

  logic [TIMER_W-1:0] hb_r, hb_nxt, hb_inc;
  logic [FLASH_W-1:0] flash_r, flash_nxt, flash_adv;

  always_comb begin
    flash_adv = flash_r;
    if (flash_r != '0) begin
      flash_adv = flash_r + 1'b1;
      if (flash_adv > FLASH_END) flash_adv = '0;
    end
    hb_inc    = sat_inc(hb_r);
    hb_nxt    = hb_inc;
    flash_nxt = flash_adv;
    // Restart the flash on every period boundary, even mid-flash.
    if (hb_inc >= period) begin
      hb_nxt    = '0;
      flash_nxt = FLASH_W'(1);
    end
    led_nxt = (flash_nxt != '0) &&
              ((flash_nxt <= FLASH_ON1_END) || (flash_nxt > FLASH_OFF_END));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_r    <= '0;
      flash_r <= '0;
    end else if (advance) begin
      hb_r    <= hb_nxt;
      flash_r <= flash_nxt;
    end
  end

endmodule

// File: src/click_hold_brightness_controller_unit.sv
// Top level of the click and hold lamp brightness controller.
//
// Usage: each input beat on in_* is one millisecond tick carrying the
// sampled active-low button pin. A short click toggles the lamp (on starts
// at level 0); a press held for the hold time steps the level at once and
// then every repeat interval while the lamp is on. After a release, samples
// are ignored for the lockout time. A heartbeat LED double-flashes each
// heartbeat period.
//
// Every input beat yields exactly one output beat in the next cycle. The whole
// tick update is one pass of logic from the state registers into the
// result register, so a beat is taken every cycle unless in_stall is high.
// When the receiver raises out_stall the result register holds and in_stall
// rises only while a finished result is still waiting.
// Configuration writes on cfg_* are always ready; write them while idle.
// Synchronous reset restores the default registers, turns the lamp off,
// selects level 0 and stops the heartbeat flash.
module click_hold_brightness_controller_unit #(
  parameter int LEVEL_COUNT = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_button_level,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [chbc_pkg::DUTY_W-1:0]      out_lamp_duty,
  output logic                             out_heartbeat_led,
  output logic                             out_lamp_is_on,
  output logic [chbc_pkg::LEVEL_W-1:0]     out_current_level,
  output logic                             out_hold_detected,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [chbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [chbc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import chbc_pkg::*;

  localparam logic [LEVEL_W:0] LEVEL_LAST = (LEVEL_W+1)'(LEVEL_COUNT);

  // Configuration registers
  logic [TIMER_W-1:0]   hold_time_r, repeat_intvl_r, hb_period_r;
  logic [LOCKOUT_W-1:0] lockout_cfg_r;
  logic [DUTY_W-1:0]    duty_r [DUTY_CNT];

  // Button state
  logic                 prev_r, prev_nxt;
  logic [TIMER_W-1:0]   press_r, press_nxt;
  logic                 hold_r, hold_nxt;
  logic                 lamp_r, lamp_nxt;
  logic [LEVEL_W-1:0]   level_r, level_nxt;
  logic [TIMER_W-1:0]   rep_r, rep_nxt;
  logic [LOCKOUT_W-1:0] lock_r, lock_nxt;

  logic accept, led_nxt;
  logic out_valid_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;

  function automatic logic [LEVEL_W-1:0] step_level(input logic [LEVEL_W-1:0] lv);
    logic [LEVEL_W:0] n;
    n = {1'b0, lv} + 1'b1;
    return (n >= LEVEL_LAST) ? '0 : n[LEVEL_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_time_r    <= RST_HOLD_TIME;
      repeat_intvl_r <= RST_REPEAT_INTVL;
      hb_period_r    <= RST_HB_PERIOD;
      lockout_cfg_r  <= RST_LOCKOUT;
      duty_r[0]      <= RST_DUTY_0;
      duty_r[1]      <= RST_DUTY_1;
      duty_r[2]      <= RST_DUTY_2;
      duty_r[3]      <= RST_DUTY_3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HOLD_TIME:    hold_time_r    <= cfg_data;
        CFG_REPEAT_INTVL: repeat_intvl_r <= cfg_data;
        CFG_HB_PERIOD:    hb_period_r    <= cfg_data;
        CFG_LOCKOUT:      lockout_cfg_r  <= cfg_data[LOCKOUT_W-1:0];
        CFG_DUTY_0:       duty_r[0]      <= cfg_data[DUTY_W-1:0];
        CFG_DUTY_1:       duty_r[1]      <= cfg_data[DUTY_W-1:0];
        CFG_DUTY_2:       duty_r[2]      <= cfg_data[DUTY_W-1:0];
        CFG_DUTY_3:       duty_r[3]      <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  chbc_heartbeat u_heartbeat (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (accept),
    .period  (hb_period_r),
    .led_nxt (led_nxt)
  );

  // One tick of the button logic.
  always_comb begin
    prev_nxt  = prev_r;
    press_nxt = press_r;
    hold_nxt  = hold_r;
    lamp_nxt  = lamp_r;
    level_nxt = level_r;
    rep_nxt   = rep_r;
    lock_nxt  = lock_r;
    if (lock_r != '0) begin
      // Ignore the sample and count the lockout down; the edge detector holds.
      lock_nxt = lock_r - 1'b1;
    end else begin
      if (!in_button_level) begin
        if (prev_r) begin
          press_nxt = '0;
          hold_nxt  = 1'b0;
        end else begin
          press_nxt = sat_inc(press_r);
        end
        if (!hold_nxt) begin
          if (press_nxt >= hold_time_r) begin
            hold_nxt = 1'b1;
            if (lamp_r) begin
              level_nxt = step_level(level_r);
              rep_nxt   = '0;
            end
          end
        end else if (lamp_r) begin
          rep_nxt = sat_inc(rep_r);
          if (rep_nxt >= repeat_intvl_r) begin
            level_nxt = step_level(level_r);
            rep_nxt   = '0;
          end
        end
      end else if (!prev_r) begin
        // Release edge: a hold just ends, a short click toggles the lamp; the lockout starts.
        if (hold_r) begin
          hold_nxt = 1'b0;
        end else if (press_r < hold_time_r) begin
          lamp_nxt = ~lamp_r;
          if (!lamp_r) level_nxt = '0;
        end
        lock_nxt = lockout_cfg_r;
      end
      prev_nxt = in_button_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b1;
      press_r <= '0;
      hold_r  <= 1'b0;
      lamp_r  <= 1'b0;
      level_r <= '0;
      rep_r   <= '0;
      lock_r  <= '0;
    end else if (accept) begin
      prev_r  <= prev_nxt;
      press_r <= press_nxt;
      hold_r  <= hold_nxt;
      lamp_r  <= lamp_nxt;
      level_r <= level_nxt;
      rep_r   <= rep_nxt;
      lock_r  <= lock_nxt;
    end
  end

  // Result register: load on every accepted tick, hold while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_lamp_duty     <= lamp_nxt ? duty_r[level_nxt] : '0;
      out_heartbeat_led <= led_nxt;
      out_lamp_is_on    <= lamp_nxt;
      out_current_level <= level_nxt;
      out_hold_detected <= hold_nxt;
    end
  end

endmodule
